/* rtl/core/elp_pkg.sv */
// Shared types, constants and the exponential table for the EIF neuron update unit.
package elp_pkg;

    localparam int SUBSTEPS       = 10;
    localparam int EXP_TABLE_BITS = 10;
    localparam int EXP_TABLE_SIZE = 1 << EXP_TABLE_BITS;

    // divider geometry: quotient of a 63-bit magnitude by slope << (30 - B)
    localparam int DEN_SHIFT = 30 - EXP_TABLE_BITS;
    localparam int DEN_W     = 31 + DEN_SHIFT;
    localparam int QUOT_BITS = 34 + EXP_TABLE_BITS;
    localparam int Q_W       = QUOT_BITS + 1;
    localparam int K_W       = Q_W - EXP_TABLE_BITS;
    localparam int DIV_CNT_W = $clog2(QUOT_BITS);
    localparam int SUB_CNT_W = $clog2(SUBSTEPS + 1);

    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [61:0] EXP_CAP   = 62'h2000_0000_0000_0000;
    localparam logic [62:0] DV_CAP    = 63'h2_0000_0000;

    localparam logic [31:0] EXC_DECAY_RST   = 32'd42949673;
    localparam logic [31:0] INH_DECAY_RST   = 32'd42949673;
    localparam logic [31:0] V_GAIN_RST      = 32'd42949673;
    localparam logic [31:0] V_RESET_RST     = 32'hF70A_3D71;
    localparam logic [31:0] V_RHEOBASE_RST  = 32'hF999_999A;
    localparam logic [31:0] V_THRESHOLD_RST = 32'd0;
    localparam logic [30:0] SLOPE_RST       = 31'd4294967;
    localparam logic [35:0] RESISTANCE_RST  = 36'd100000000;

    localparam logic [2:0] REG_EXC_DECAY   = 3'd0;
    localparam logic [2:0] REG_INH_DECAY   = 3'd1;
    localparam logic [2:0] REG_V_GAIN      = 3'd2;
    localparam logic [2:0] REG_V_RESET     = 3'd3;
    localparam logic [2:0] REG_V_RHEOBASE  = 3'd4;
    localparam logic [2:0] REG_V_THRESHOLD = 3'd5;
    localparam logic [2:0] REG_SLOPE       = 3'd6;
    localparam logic [2:0] REG_RESISTANCE  = 3'd7;

    typedef logic [31:0] exp_table_t [EXP_TABLE_SIZE];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_DIV,
        ST_QUOT,
        ST_ROM,
        ST_EXPMUL,
        ST_EXPSH,
        ST_SUM,
        ST_GAIN,
        ST_DV,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic prep;
        logic setup;
        logic div_step;
        logic quot;
        logic rom;
        logic expmul;
        logic expsh;
        logic sum;
        logic gain;
        logic dv;
        logic upd;
        logic finish;
    } cmd_t;

    // 2^(i/2^B) in Q2.30 from a twelfth-order Taylor series, evaluated at elaboration
    function automatic exp_table_t exp_table_init();
        exp_table_t tab;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] acc;
        for (int i = 0; i < EXP_TABLE_SIZE; i++)
        begin
            f = 64'(i) << DEN_SHIFT;
            t = (f * LN2_Q30) >> 30;
            acc = ONE_Q30;
            for (int n = 12; n >= 1; n--)
            begin
                acc = ONE_Q30 + ((acc * t) >> 30) / 64'(n);
            end
            tab[i] = acc[31:0];
        end
        return tab;
    endfunction

endpackage

/* rtl/core/elp_ctrl.sv */
// Sequencer for the neuron update: handshakes, substep and divider counters.
module elp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          operation,
    output logic          in_ready,
    input  logic          out_ready,
    output logic          out_valid,
    output elp_pkg::cmd_t cmd
);

    elp_pkg::state_t state_reg, state_next;
    logic [elp_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [elp_pkg::SUB_CNT_W-1:0] sub_cnt_reg, sub_cnt_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= elp_pkg::ST_IDLE;
            div_cnt_reg   <= '0;
            sub_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            sub_cnt_reg   <= sub_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == elp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        sub_cnt_next   = sub_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            elp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load     = operation;
                    cmd.tick     = !operation;
                    sub_cnt_next = '0;
                    state_next   = operation ? elp_pkg::ST_DONE : elp_pkg::ST_PREP;
                end
            end
            elp_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = elp_pkg::ST_SETUP;
            end
            elp_pkg::ST_SETUP:
            begin
                cmd.setup    = 1'b1;
                div_cnt_next = '0;
                state_next   = elp_pkg::ST_DIV;
            end
            elp_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == elp_pkg::DIV_CNT_W'(elp_pkg::QUOT_BITS - 1))
                begin
                    state_next = elp_pkg::ST_QUOT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            elp_pkg::ST_QUOT:
            begin
                cmd.quot   = 1'b1;
                state_next = elp_pkg::ST_ROM;
            end
            elp_pkg::ST_ROM:
            begin
                cmd.rom    = 1'b1;
                state_next = elp_pkg::ST_EXPMUL;
            end
            elp_pkg::ST_EXPMUL:
            begin
                cmd.expmul = 1'b1;
                state_next = elp_pkg::ST_EXPSH;
            end
            elp_pkg::ST_EXPSH:
            begin
                cmd.expsh  = 1'b1;
                state_next = elp_pkg::ST_SUM;
            end
            elp_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = elp_pkg::ST_GAIN;
            end
            elp_pkg::ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = elp_pkg::ST_DV;
            end
            elp_pkg::ST_DV:
            begin
                cmd.dv     = 1'b1;
                state_next = elp_pkg::ST_UPD;
            end
            elp_pkg::ST_UPD:
            begin
                cmd.upd = 1'b1;
                if (sub_cnt_reg == elp_pkg::SUB_CNT_W'(elp_pkg::SUBSTEPS - 1))
                begin
                    state_next = elp_pkg::ST_DONE;
                end
                else
                begin
                    sub_cnt_next = sub_cnt_reg + 1'b1;
                    state_next   = elp_pkg::ST_PREP;
                end
            end
            elp_pkg::ST_DONE:
            begin
                // hold until the output word has gone
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = elp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = elp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/elp_datapath.sv */
// Datapath: configuration, neuron state, divider, exponential table and Euler update.
module elp_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  elp_pkg::cmd_t cmd,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [35:0]   cfg_data,
    input  logic          exc_enable,
    input  logic          inh_enable,
    input  logic [31:0]   exc_inject,
    input  logic [31:0]   inh_inject,
    input  logic [31:0]   load_voltage,
    input  logic [31:0]   load_exc,
    input  logic [31:0]   load_inh,
    output logic          spiked,
    output logic [3:0]    spike_count,
    output logic [31:0]   voltage_out,
    output logic [31:0]   exc_out,
    output logic [31:0]   inh_out
);

    localparam elp_pkg::exp_table_t EXP_ROM = elp_pkg::exp_table_init();
    localparam int DW = elp_pkg::DEN_W;
    localparam int QB = elp_pkg::QUOT_BITS;
    localparam int TB = elp_pkg::EXP_TABLE_BITS;
    localparam int KW = elp_pkg::K_W;

    // configuration
    logic [31:0] exc_decay_reg, inh_decay_reg, v_gain_reg;
    logic [31:0] v_reset_reg, v_rheobase_reg, v_threshold_reg;
    logic [30:0] slope_reg;
    logic [35:0] resistance_reg;

    // neuron state
    logic [31:0] membrane_reg, exc_cur_reg, inh_cur_reg, exc_lag_reg, inh_lag_reg;
    logic        exc_en_reg, inh_en_reg;
    logic [3:0]  count_reg;
    logic [31:0] vout_reg, eout_reg, iout_reg;

    // working registers
    logic [62:0]    num_abs_reg;
    logic           num_neg_reg;
    logic [49:0]    p_hi_reg, p_lo_reg;
    logic           res_neg_reg;
    logic [51:0]    res_mag_reg;
    logic [31:0]    exc_prod_reg, inh_prod_reg, exc_dec_reg, inh_dec_reg;
    logic [DW-1:0]  rem_reg;
    logic [QB-1:0]  div_reg;
    logic [KW-1:0]  k_reg;
    logic [TB-1:0]  f_reg;
    logic [31:0]    rom_data_reg;
    logic [62:0]    prod_reg;
    logic [61:0]    exp_reg;
    logic           sum_neg_reg;
    logic [61:0]    sum_mag_reg;
    logic [61:0]    mh_reg;
    logic [63:0]    ml_reg;
    logic [34:0]    dv_reg;

    // output word
    logic        spiked_reg;
    logic [3:0]  spike_count_reg;
    logic [31:0] voltage_out_reg, exc_out_reg, inh_out_reg;

    logic [30:0]   slope_eff;
    logic [DW-1:0] den;
    logic [32:0]   diff;
    logic [32:0]   diff_abs;
    logic [32:0]   di;
    logic [31:0]   di_abs;
    logic [31:0]   exc_abs, inh_abs;
    logic [32:0]   exc_sum, inh_sum;
    logic [DW:0]   rem_sh;
    logic          ge;
    logic [elp_pkg::Q_W-1:0] q_val;
    logic [KW-1:0] sh_left, sh_right;
    logic [61:0]   cap_sh;
    logic [61:0]   exp_val;
    logic [63:0]   sum_val;
    logic [62:0]   dv_mag;
    logic [33:0]   dv_clamp;
    logic [35:0]   nv;
    logic [31:0]   nv_sat;
    logic          fire;

    assign slope_eff = (slope_reg == '0) ? 31'd1 : slope_reg;
    assign den       = DW'(slope_eff) << elp_pkg::DEN_SHIFT;

    always_comb
    begin
        diff     = {membrane_reg[31], membrane_reg} - {v_rheobase_reg[31], v_rheobase_reg};
        diff_abs = diff[32] ? (33'd0 - diff) : diff;
        di       = {exc_lag_reg[31], exc_lag_reg} - {inh_lag_reg[31], inh_lag_reg};
        di_abs   = di[32] ? 32'(33'd0 - di) : di[31:0];
        exc_abs  = exc_cur_reg[31] ? (32'd0 - exc_cur_reg) : exc_cur_reg;
        inh_abs  = inh_cur_reg[31] ? (32'd0 - inh_cur_reg) : inh_cur_reg;
        exc_sum  = {exc_cur_reg[31], exc_cur_reg} + {exc_inject[31], exc_inject};
        inh_sum  = {inh_cur_reg[31], inh_cur_reg} + {inh_inject[31], inh_inject};
    end

    // one quotient bit a cycle
    always_comb
    begin
        rem_sh = {rem_reg, div_reg[QB-1]};
        ge     = (rem_sh >= {1'b0, den});
    end

    always_comb
    begin
        if (num_neg_reg)
        begin
            q_val = elp_pkg::Q_W'(0) - ({1'b0, div_reg} + elp_pkg::Q_W'(rem_reg != '0));
        end
        else
        begin
            q_val = {1'b0, div_reg};
        end
    end

    // scale the product of slope and table entry by 2^(k-30), saturating
    always_comb
    begin
        sh_left  = k_reg - KW'(30);
        sh_right = KW'(30) - k_reg;
        cap_sh   = elp_pkg::EXP_CAP >> sh_left[5:0];
        if (!k_reg[KW-1] && (k_reg >= KW'(30)))
        begin
            if ((sh_left >= KW'(62)) || (prod_reg > {1'b0, cap_sh}))
            begin
                exp_val = elp_pkg::EXP_CAP;
            end
            else
            begin
                exp_val = 62'(prod_reg << sh_left[5:0]);
            end
        end
        else
        begin
            if (sh_right >= KW'(63))
            begin
                exp_val = '0;
            end
            else
            begin
                exp_val = 62'(prod_reg >> sh_right[5:0]);
            end
        end
    end

    always_comb
    begin
        sum_val = {{32{v_reset_reg[31]}}, v_reset_reg} - {{32{membrane_reg[31]}}, membrane_reg}
                  + {2'b00, exp_reg};
        if (res_neg_reg)
        begin
            sum_val = sum_val - {12'd0, res_mag_reg};
        end
        else
        begin
            sum_val = sum_val + {12'd0, res_mag_reg};
        end
        dv_mag   = {1'b0, mh_reg} + {31'd0, ml_reg[63:32]};
        dv_clamp = (dv_mag > elp_pkg::DV_CAP) ? elp_pkg::DV_CAP[33:0] : dv_mag[33:0];
        nv       = {{4{membrane_reg[31]}}, membrane_reg} + {dv_reg[34], dv_reg};
        if ($signed(nv) > 36'sh0_7FFF_FFFF)
        begin
            nv_sat = 32'h7FFF_FFFF;
        end
        else if ($signed(nv) < -36'sh0_8000_0000)
        begin
            nv_sat = 32'h8000_0000;
        end
        else
        begin
            nv_sat = nv[31:0];
        end
        fire = ($signed(nv_sat) > $signed(v_threshold_reg));
    end

    // configuration and neuron state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exc_decay_reg   <= elp_pkg::EXC_DECAY_RST;
            inh_decay_reg   <= elp_pkg::INH_DECAY_RST;
            v_gain_reg      <= elp_pkg::V_GAIN_RST;
            v_reset_reg     <= elp_pkg::V_RESET_RST;
            v_rheobase_reg  <= elp_pkg::V_RHEOBASE_RST;
            v_threshold_reg <= elp_pkg::V_THRESHOLD_RST;
            slope_reg       <= elp_pkg::SLOPE_RST;
            resistance_reg  <= elp_pkg::RESISTANCE_RST;
            membrane_reg    <= '0;
            exc_cur_reg     <= '0;
            inh_cur_reg     <= '0;
            exc_lag_reg     <= '0;
            inh_lag_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    elp_pkg::REG_EXC_DECAY:   exc_decay_reg   <= cfg_data[31:0];
                    elp_pkg::REG_INH_DECAY:   inh_decay_reg   <= cfg_data[31:0];
                    elp_pkg::REG_V_GAIN:      v_gain_reg      <= cfg_data[31:0];
                    elp_pkg::REG_V_RESET:     v_reset_reg     <= cfg_data[31:0];
                    elp_pkg::REG_V_RHEOBASE:  v_rheobase_reg  <= cfg_data[31:0];
                    elp_pkg::REG_V_THRESHOLD: v_threshold_reg <= cfg_data[31:0];
                    elp_pkg::REG_SLOPE:       slope_reg       <= cfg_data[30:0];
                    elp_pkg::REG_RESISTANCE:  resistance_reg  <= cfg_data;
                    default:                  ;
                endcase
            end
            if (cmd.load)
            begin
                membrane_reg <= load_voltage;
                exc_cur_reg  <= load_exc;
                inh_cur_reg  <= load_inh;
            end
            if (cmd.tick)
            begin
                // saturating injection
                if (exc_sum[32] != exc_sum[31])
                begin
                    exc_cur_reg <= exc_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    exc_cur_reg <= exc_sum[31:0];
                end
                if (inh_sum[32] != inh_sum[31])
                begin
                    inh_cur_reg <= inh_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    inh_cur_reg <= inh_sum[31:0];
                end
            end
            if (cmd.upd)
            begin
                membrane_reg <= fire ? v_reset_reg : nv_sat;
                if (exc_en_reg)
                begin
                    exc_lag_reg <= exc_cur_reg;
                    exc_cur_reg <= exc_dec_reg;
                end
                if (inh_en_reg)
                begin
                    inh_lag_reg <= inh_cur_reg;
                    inh_cur_reg <= inh_dec_reg;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            count_reg <= '0;
            vout_reg  <= load_voltage;
            eout_reg  <= load_exc;
            iout_reg  <= load_inh;
        end
        if (cmd.tick)
        begin
            count_reg  <= '0;
            exc_en_reg <= exc_enable;
            inh_en_reg <= inh_enable;
        end
        if (cmd.prep)
        begin
            num_abs_reg  <= 63'(diff_abs) * 63'(elp_pkg::LOG2E_Q30);
            num_neg_reg  <= diff[32];
            p_hi_reg     <= di_abs * resistance_reg[35:18];
            p_lo_reg     <= di_abs * resistance_reg[17:0];
            res_neg_reg  <= di[32];
            exc_prod_reg <= 32'((64'(exc_abs) * 64'(exc_decay_reg)) >> 32);
            inh_prod_reg <= 32'((64'(inh_abs) * 64'(inh_decay_reg)) >> 32);
        end
        if (cmd.setup)
        begin
            rem_reg     <= DW'(num_abs_reg[62:QB]);
            div_reg     <= num_abs_reg[QB-1:0];
            res_mag_reg <= {1'b0, p_hi_reg, 1'b0} + {19'd0, p_lo_reg[49:17]};
            exc_dec_reg <= exc_cur_reg[31] ? (exc_cur_reg + exc_prod_reg)
                                           : (exc_cur_reg - exc_prod_reg);
            inh_dec_reg <= inh_cur_reg[31] ? (inh_cur_reg + inh_prod_reg)
                                           : (inh_cur_reg - inh_prod_reg);
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
            div_reg <= {div_reg[QB-2:0], ge};
        end
        if (cmd.quot)
        begin
            k_reg <= q_val[elp_pkg::Q_W-1:TB];
            f_reg <= q_val[TB-1:0];
        end
        if (cmd.rom)
        begin
            rom_data_reg <= EXP_ROM[f_reg];
        end
        if (cmd.expmul)
        begin
            prod_reg <= slope_eff * rom_data_reg;
        end
        if (cmd.expsh)
        begin
            exp_reg <= exp_val;
        end
        if (cmd.sum)
        begin
            sum_neg_reg <= sum_val[63];
            sum_mag_reg <= sum_val[63] ? 62'(64'd0 - sum_val) : sum_val[61:0];
        end
        if (cmd.gain)
        begin
            mh_reg <= sum_mag_reg[61:32] * v_gain_reg;
            ml_reg <= sum_mag_reg[31:0] * v_gain_reg;
        end
        if (cmd.dv)
        begin
            dv_reg <= sum_neg_reg ? (35'd0 - {1'b0, dv_clamp}) : {1'b0, dv_clamp};
        end
        if (cmd.upd)
        begin
            vout_reg <= fire ? v_reset_reg : nv_sat;
            eout_reg <= exc_cur_reg;
            iout_reg <= inh_cur_reg;
            if (fire && (count_reg != 4'hF))
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
        if (cmd.finish)
        begin
            spiked_reg      <= (count_reg != '0);
            spike_count_reg <= count_reg;
            voltage_out_reg <= vout_reg;
            exc_out_reg     <= eout_reg;
            inh_out_reg     <= iout_reg;
        end
    end

    assign spiked      = spiked_reg;
    assign spike_count = spike_count_reg;
    assign voltage_out = voltage_out_reg;
    assign exc_out     = exc_out_reg;
    assign inh_out     = inh_out_reg;

endmodule

/* rtl/core/exp_lif_neuron_update_unit.sv */
// A tick word runs ten substeps, each using the bit-serial divider for the exponent, and
// then fills the output register; a load word fills the output register directly.
// One word at a time; the next word is taken once the result is in the output register,
// and the output register is refilled only after the previous result has been taken.
// Reset: asynchronous, active low; state and currents clear to zero and the
// configuration registers return to their defaults.
module exp_lif_neuron_update_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic        exc_enable,
    input  logic        inh_enable,
    input  logic [31:0] exc_inject,
    input  logic [31:0] inh_inject,
    input  logic [31:0] load_voltage,
    input  logic [31:0] load_exc,
    input  logic [31:0] load_inh,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        spiked,
    output logic [3:0]  spike_count,
    output logic [31:0] voltage_out,
    output logic [31:0] exc_out,
    output logic [31:0] inh_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [35:0] cfg_data
);

    elp_pkg::cmd_t cmd;

    elp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    elp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .exc_enable   (exc_enable),
        .inh_enable   (inh_enable),
        .exc_inject   (exc_inject),
        .inh_inject   (inh_inject),
        .load_voltage (load_voltage),
        .load_exc     (load_exc),
        .load_inh     (load_inh),
        .spiked       (spiked),
        .spike_count  (spike_count),
        .voltage_out  (voltage_out),
        .exc_out      (exc_out),
        .inh_out      (inh_out)
    );

endmodule

/* dv/tb.sv */
// Testbench for the exponential integrate-and-fire neuron update unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;
    localparam int   N_SUB   = elp_pkg::SUBSTEPS;
    localparam int   TAB_B   = elp_pkg::EXP_TABLE_BITS;
    localparam int   WDOG_LIMIT = 5000;

    typedef struct {
        logic        op;
        logic        een;
        logic        ien;
        logic [31:0] e_inj;
        logic [31:0] i_inj;
        logic [31:0] l_v;
        logic [31:0] l_e;
        logic [31:0] l_i;
    } neuron_word_t;

    typedef struct {
        logic        spk;
        logic [3:0]  cnt;
        logic [31:0] v;
        logic [31:0] e;
        logic [31:0] i;
    } tick_result_t;

    class spike_scoreboard;
        bit [31:0]        exp2_tab [1 << TAB_B];
        bit [31:0]        exc_decay_r, inh_decay_r, v_gain_r;
        bit signed [31:0] v_reset_r, v_rheo_r, v_thr_r;
        bit [30:0]        slope_r;
        bit [35:0]        res_r;
        bit signed [31:0] membrane, exc_i, inh_i, exc_lag, inh_lag;
        tick_result_t     awaited [$];
        int               errors;

        function new();
            longint unsigned t, acc;
            exc_decay_r = 32'd42949673;
            inh_decay_r = 32'd42949673;
            v_gain_r    = 32'd42949673;
            v_reset_r   = -32'sd150323855;
            v_rheo_r    = -32'sd107374182;
            v_thr_r     = 0;
            slope_r     = 31'd4294967;
            res_r       = 36'd100000000;
            membrane = 0; exc_i = 0; inh_i = 0; exc_lag = 0; inh_lag = 0;
            errors = 0;
            for (int i = 0; i < (1 << TAB_B); i++)
            begin
                t = ((longint'(i) << (30 - TAB_B)) * 64'd744261118) >> 30;
                acc = 64'd1073741824;
                for (int n = 12; n >= 1; n--)
                    acc = 64'd1073741824 + ((acc * t) >> 30) / longint'(n);
                exp2_tab[i] = acc[31:0];
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [35:0] d);
            case (idx)
                elp_pkg::REG_EXC_DECAY:   exc_decay_r = d[31:0];
                elp_pkg::REG_INH_DECAY:   inh_decay_r = d[31:0];
                elp_pkg::REG_V_GAIN:      v_gain_r    = d[31:0];
                elp_pkg::REG_V_RESET:     v_reset_r   = d[31:0];
                elp_pkg::REG_V_RHEOBASE:  v_rheo_r    = d[31:0];
                elp_pkg::REG_V_THRESHOLD: v_thr_r     = d[31:0];
                elp_pkg::REG_SLOPE:       slope_r     = d[30:0];
                elp_pkg::REG_RESISTANCE:  res_r       = d;
                default: ;
            endcase
        endfunction

        function longint unsigned gain_mul(longint unsigned mag, bit [31:0] g);
            longint unsigned gg;
            gg = {32'd0, g};
            return (mag >> 32) * gg + (((mag & 64'hFFFF_FFFF) * gg) >> 32);
        endfunction

        function longint gain_scale(longint v, bit [31:0] g);
            if (v < 0)
                return -longint'(gain_mul(-v, g));
            return longint'(gain_mul(v, g));
        endfunction

        function longint fdiv(longint n, longint d);
            if (n >= 0)
                return n / d;
            return -((-n + d - 1) / d);
        endfunction

        function bit signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function longint exp_rise(longint v);
            longint s, num, q, k, f, sh;
            longint unsigned prod, cap;
            cap = 64'h2000_0000_0000_0000;
            s = (slope_r != 0) ? longint'({33'd0, slope_r}) : 1;
            num = (v - longint'(v_rheo_r)) * 64'sd1549082005;
            q = fdiv(num, s << (30 - TAB_B));
            k = fdiv(q, 64'sd1 << TAB_B);
            f = q - k * (64'sd1 << TAB_B);
            prod = longint'(s) * longint'({32'd0, exp2_tab[f[TAB_B-1:0]]});
            if (k >= 30)
            begin
                sh = k - 30;
                if (sh >= 62 || prod > (cap >> sh))
                    return longint'(cap);
                return longint'(prod << sh);
            end
            sh = 30 - k;
            if (sh >= 63)
                return 0;
            return longint'(prod >> sh);
        endfunction

        function longint drive_term();
            longint di;
            longint unsigned mag, r, m;
            di = longint'(exc_lag) - longint'(inh_lag);
            mag = (di < 0) ? -di : di;
            r = {28'd0, res_r};
            m = mag * (r >> 18) * 2 + ((mag * (r & 64'h3FFFF)) >> 17);
            return (di < 0) ? -longint'(m) : longint'(m);
        endfunction

        function bit signed [31:0] leak(bit signed [31:0] cur, bit [31:0] g);
            longint r;
            r = longint'(cur) - gain_scale(longint'(cur), g);
            return r[31:0];
        endfunction

        function void note_word(neuron_word_t w);
            tick_result_t r;
            longint v, sum, dv;
            int cnt;
            cnt = 0;
            if (w.op == OP_LOAD)
            begin
                membrane = w.l_v; exc_i = w.l_e; inh_i = w.l_i;
                r.v = membrane; r.e = exc_i; r.i = inh_i;
            end
            else
            begin
                exc_i = clip32(longint'(exc_i) + longint'(signed'(w.e_inj)));
                inh_i = clip32(longint'(inh_i) + longint'(signed'(w.i_inj)));
                r.v = membrane; r.e = exc_i; r.i = inh_i;
                for (int s = 0; s < N_SUB; s++)
                begin
                    v = longint'(membrane);
                    sum = -(v - longint'(v_reset_r)) + exp_rise(v) + drive_term();
                    dv = gain_scale(sum, v_gain_r);
                    if (dv > 64'sd8589934592) dv = 64'sd8589934592;
                    if (dv < -64'sd8589934592) dv = -64'sd8589934592;
                    membrane = clip32(v + dv);
                    if (membrane > v_thr_r)
                    begin
                        membrane = v_reset_r;
                        if (cnt < 15) cnt++;
                    end
                    r.v = membrane; r.e = exc_i; r.i = inh_i;
                    if (w.een)
                    begin
                        exc_lag = exc_i;
                        exc_i = leak(exc_i, exc_decay_r);
                    end
                    if (w.ien)
                    begin
                        inh_lag = inh_i;
                        inh_i = leak(inh_i, inh_decay_r);
                    end
                end
            end
            r.spk = (cnt != 0);
            r.cnt = cnt[3:0];
            awaited = {awaited, r};
        endfunction

        function void check_result(tick_result_t a);
            tick_result_t x;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with none awaited v=%h", $realtime, a.v);
                errors++;
                return;
            end
            x = awaited.pop_front();
            if (a.spk !== x.spk)
            begin
                $display("%0t: spiked exp %b got %b", $realtime, x.spk, a.spk);
                errors++;
            end
            if (a.cnt !== x.cnt)
            begin
                $display("%0t: spike_count exp %0d got %0d", $realtime, x.cnt, a.cnt);
                errors++;
            end
            if (a.v !== x.v)
            begin
                $display("%0t: voltage_out exp %h got %h", $realtime, x.v, a.v);
                errors++;
            end
            if (a.e !== x.e)
            begin
                $display("%0t: exc_out exp %h got %h", $realtime, x.e, a.e);
                errors++;
            end
            if (a.i !== x.i)
            begin
                $display("%0t: inh_out exp %h got %h", $realtime, x.i, a.i);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = OP_TICK;
    logic        exc_enable = 1'b0;
    logic        inh_enable = 1'b0;
    logic [31:0] exc_inject = '0;
    logic [31:0] inh_inject = '0;
    logic [31:0] load_voltage = '0;
    logic [31:0] load_exc = '0;
    logic [31:0] load_inh = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        spiked;
    logic [3:0]  spike_count;
    logic [31:0] voltage_out;
    logic [31:0] exc_out;
    logic [31:0] inh_out;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = elp_pkg::REG_EXC_DECAY;
    logic [35:0] cfg_data = '0;

    spike_scoreboard sb = new();
    int quiet_cycles = 0;
    int ready_mode = 0;
    int mode_left = 0;

    exp_lif_neuron_update_unit u_top (.*);

    always #2 clk = ~clk;

    // note accepted words and check results on the same edge
    always @(posedge clk)
    begin
        neuron_word_t w;
        tick_result_t r;
        if (in_valid && in_ready)
        begin
            w.op = operation; w.een = exc_enable; w.ien = inh_enable;
            w.e_inj = exc_inject; w.i_inj = inh_inject;
            w.l_v = load_voltage; w.l_e = load_exc; w.l_i = load_inh;
            sb.note_word(w);
        end
        if (out_valid && out_ready)
        begin
            r.spk = spiked; r.cnt = spike_count; r.v = voltage_out;
            r.e = exc_out; r.i = inh_out;
            sb.check_result(r);
        end
    end

    // receiver stall pattern: free-running, random, or long stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 400);
        end
        else
            mode_left <= mode_left - 1;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            3: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'($signed($urandom_range(0, 400000000)) - 200000000);
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic neuron_word_t random_word();
        neuron_word_t w;
        w.op = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_TICK;
        w.een = $urandom_range(0, 1);
        w.ien = $urandom_range(0, 1);
        w.e_inj = pick32(); w.i_inj = pick32();
        w.l_v = pick32(); w.l_e = pick32(); w.l_i = pick32();
        return w;
    endfunction

    function automatic neuron_word_t mk(logic op, logic een, logic ien, logic [31:0] a,
                                        logic [31:0] b, logic [31:0] c);
        neuron_word_t w;
        w.op = op; w.een = een; w.ien = ien;
        w.e_inj = a; w.i_inj = b; w.l_v = a; w.l_e = b; w.l_i = c;
        return w;
    endfunction

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(neuron_word_t w);
        in_valid <= 1'b1;
        operation <= w.op; exc_enable <= w.een; inh_enable <= w.ien;
        exc_inject <= w.e_inj; inh_inject <= w.i_inj;
        load_voltage <= w.l_v; load_exc <= w.l_e; load_inh <= w.l_i;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [35:0] d);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic program_all(logic [31:0] ed, logic [31:0] id, logic [31:0] g,
                               logic [31:0] vr, logic [31:0] vh, logic [31:0] vt,
                               logic [30:0] sl, logic [35:0] rs);
        write_reg(elp_pkg::REG_EXC_DECAY, {4'd0, ed});
        write_reg(elp_pkg::REG_INH_DECAY, {4'd0, id});
        write_reg(elp_pkg::REG_V_GAIN, {4'd0, g});
        write_reg(elp_pkg::REG_V_RESET, {4'd0, vr});
        write_reg(elp_pkg::REG_V_RHEOBASE, {4'd0, vh});
        write_reg(elp_pkg::REG_V_THRESHOLD, {4'd0, vt});
        write_reg(elp_pkg::REG_SLOPE, {5'd0, sl});
        write_reg(elp_pkg::REG_RESISTANCE, rs);
        cfg_we <= 1'b0;
    endtask

    // bursts of one to twelve back-to-back words, separated by random gaps
    task automatic random_words(int n);
        int burst;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
        begin
            send_word(random_word());
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        neuron_word_t dir [$];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir = {dir, mk(OP_TICK, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0)};
        dir = {dir, mk(OP_LOAD, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000)};
        dir = {dir, mk(OP_TICK, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0)};
        dir = {dir, mk(OP_TICK, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0)};
        dir = {dir, mk(OP_TICK, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'd0)};
        dir = {dir, mk(OP_LOAD, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF)};
        dir = {dir, mk(OP_TICK, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0)};
        dir = {dir, mk(OP_LOAD, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'd1000000, 32'd0)};
        dir = {dir, mk(OP_TICK, 1'b1, 1'b1, 32'd1000000, 32'd0, 32'd0)};
        dir = {dir, mk(OP_TICK, 1'b1, 1'b1, 32'd100000000, 32'd0, 32'd0)};
        dir = {dir, mk(OP_LOAD, 1'b0, 1'b0, 32'd5, 32'd0, 32'd0)};
        dir = {dir, mk(OP_TICK, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0)};
        dir = {dir, mk(OP_LOAD, 1'b0, 1'b0, 32'hF999_999A, 32'h0010_0000, 32'h0000_1000)};
        dir = {dir, mk(OP_TICK, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0)};
        dir = {dir, mk(OP_TICK, 1'b1, 1'b0, 32'hFFFF_0000, 32'h0000_FFFF, 32'd0)};
        foreach (dir[k])
            send_word(dir[k]);
        drain();

        // zero slope, zero gains and decays
        program_all(32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    31'd0, 36'd0);
        random_words(60);
        drain();
        // largest gains, slope and resistance
        program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 36'hF_FFFF_FFFF);
        random_words(60);
        drain();
        program_all(32'd42949673, 32'd42949673, 32'd42949673, 32'hF70A_3D71,
                    32'hF999_999A, 32'd0, 31'd4294967, 36'd100000000);
        random_words(110);
        drain();
        program_all(32'd429496729, 32'd42949673, 32'd858993459, 32'hF70A_3D71,
                    32'hF999_999A, 32'h0100_0000, 31'd1, 36'd1000);
        random_words(60);
        for (int p = 0; p < 3; p++)
        begin
            drain();
            program_all($urandom, $urandom, $urandom_range(0, 1073741824),
                        32'($signed($urandom_range(0, 400000000)) - 300000000),
                        32'($signed($urandom_range(0, 400000000)) - 250000000),
                        32'($signed($urandom_range(0, 400000000)) - 100000000),
                        31'($urandom_range(1, 200000000)), {4'($urandom), 32'($urandom)});
            random_words(85);
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* files.f */
rtl/core/elp_pkg.sv
rtl/core/elp_ctrl.sv
rtl/core/elp_datapath.sv
rtl/core/exp_lif_neuron_update_unit.sv
dv/tb.sv
